// ----- rtl/core/b2d_pkg.sv -----
// Shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2d_pkg;

  // Width of the binary number that is converted (8 to 32).
  localparam int VALUE_BITS   = 32;
  // Width of the input field on the port.
  localparam int IN_W         = 32;
  // Width of one ASCII digit result.
  localparam int CHAR_W       = 6;

  // Decimal digits needed for VALUE_BITS bits: floor(VALUE_BITS * log10(2)) + 1.
  localparam int DIGITS       = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W        = DIGITS * 4;
  localparam int DIGIT_IDX_W  = $clog2(DIGITS);

  // Double-dabble pipeline geometry.
  localparam int DD_STAGES    = 4;
  localparam int BITS_PER_STG = (VALUE_BITS + DD_STAGES - 1) / DD_STAGES;
  localparam int PAD_W        = DD_STAGES * BITS_PER_STG;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // One beat travelling down the conversion pipeline.
  typedef struct packed {
    logic             vld;
    logic [BCD_W-1:0] bcd;
    logic [PAD_W-1:0] bin;
  } dd_beat_t;

endpackage

// ----- rtl/core/b2d_dd_stage.sv -----
// One register stage of the double-dabble binary to BCD conversion.
`timescale 1ns / 1ps

module b2d_dd_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  b2d_pkg::dd_beat_t beat_i,
  output b2d_pkg::dd_beat_t beat_o
);
  import b2d_pkg::*;

  logic             vld_r;
  logic             vld_nxt;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [PAD_W-1:0] bin_r;
  logic [PAD_W-1:0] bin_nxt;

  // Each step corrects every BCD digit of five or more by adding three,
  // then shifts the next binary bit in from the top of the remaining value.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [PAD_W-1:0] v;
    b = beat_i.bcd;
    v = beat_i.bin;
    for (int s = 0; s < BITS_PER_STG; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], v[PAD_W-1]};
      v = {v[PAD_W-2:0], 1'b0};
    end
    bcd_nxt = b;
    bin_nxt = v;
    vld_nxt = load ? beat_i.vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign beat_o.vld = vld_r;
  assign beat_o.bcd = bcd_r;
  assign beat_o.bin = bin_r;

endmodule

// ----- rtl/core/b2d_serializer.sv -----
// Output stage that sends the BCD digits as ASCII characters, one per beat.
`timescale 1ns / 1ps

module b2d_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  b2d_pkg::dd_beat_t           beat_i,
  output logic                        ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);
  import b2d_pkg::*;

  logic                   valid_r;
  logic                   valid_nxt;
  logic [BCD_W-1:0]       digits_r;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_IDX_W-1:0] idx_nxt;
  logic [DIGIT_IDX_W-1:0] top_idx;
  logic                   out_take;
  logic                   at_last;
  logic                   load;

  // Position of the most significant nonzero digit; zero when the number is zero.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (beat_i.bcd[d*4 +: 4] != 4'd0) begin
        top_idx = DIGIT_IDX_W'(d);
      end
    end
  end

  assign at_last  = (idx_r == '0);
  assign out_take = valid_r && !out_stall;
  assign ready    = !valid_r || (out_take && at_last);
  assign load     = ready && beat_i.vld;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = top_idx;
    end else if (out_take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - DIGIT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load) begin
      digits_r <= beat_i.bcd;
    end
  end

  assign out_valid      = valid_r;
  assign out_digit_char = ASCII_ZERO + CHAR_W'(digits_r[idx_r*4 +: 4]);
  assign out_last_digit = at_last;

endmodule

// ----- rtl/core/binary_to_decimal_ascii_top.sv -----
// Top level of the binary to decimal ASCII converter.
`timescale 1ns / 1ps

//  Channel | Ports                                       | Direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_stall, in_value[31:0]          | one number per beat
//  result  | out_valid, out_stall, out_digit_char[5:0],  | one digit per beat,
//          | out_last_digit                              | most significant first
//
// A number enters a four-stage double-dabble pipeline (eight bit steps per stage)
// and its first digit reaches the result port through the stage registers and
// the serializer register. The serializer sends one digit per beat, so a number
// occupies the output one beat per digit, 1 to 10; that sets the sustained rate.
// Reset (rst_n low, synchronous) clears only the valid bits of the pipeline
// and of the serializer. A stall on the result side backs up stage by stage;
// no beat is dropped or repeated, and the pipeline fills while the serializer works.

module binary_to_decimal_ascii_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [b2d_pkg::IN_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit
);
  import b2d_pkg::*;

  // beat[i] feeds stage i; beat[DD_STAGES] is the last stage's register.
  dd_beat_t             beat [DD_STAGES+1];
  // rdy[i] is high when stage i may load a new beat this cycle.
  logic [DD_STAGES:0]   rdy;
  logic                 ser_ready;

  // Bits above VALUE_BITS are dropped; the value is padded to the pipeline width.
  assign beat[0].vld = in_valid;
  assign beat[0].bcd = '0;
  assign beat[0].bin = PAD_W'(in_value[VALUE_BITS-1:0]);

  assign rdy[DD_STAGES] = ser_ready;

  // A stage may load when it is empty or when its contents move on this cycle.
  for (genvar g = 0; g < DD_STAGES; g++) begin : g_stage
    assign rdy[g] = !beat[g+1].vld || rdy[g+1];

    b2d_dd_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (rdy[g]),
      .beat_i (beat[g]),
      .beat_o (beat[g+1])
    );
  end

  assign in_stall = !rdy[0];

  b2d_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .beat_i         (beat[DD_STAGES]),
    .ready          (ser_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

// ----- rtl/core/b2d_checker.sv -----
// Port-level checker for the converter and its bind to the top level.
`timescale 1ns / 1ps

module b2d_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [b2d_pkg::CHAR_W-1:0]  out_digit_char,
  input  logic                        out_last_digit
);
  import b2d_pkg::*;

  logic                   first_r;
  logic [DIGIT_IDX_W-1:0] cnt_r;
  logic                   take;

  assign take = out_valid && !out_stall;

  // Tracks the start of each number and the digits sent so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else if (take) begin
      first_r <= out_last_digit;
      cnt_r   <= out_last_digit ? '0 : cnt_r + DIGIT_IDX_W'(1);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char)
                               && $stable(out_last_digit))
    else $error("stalled result beat changed");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && out_digit_char == ASCII_ZERO |-> out_last_digit)
    else $error("leading zero digit sent");

  a_max_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == DIGIT_IDX_W'(DIGITS - 1) |-> out_last_digit)
    else $error("number has too many digits");

endmodule

bind binary_to_decimal_ascii_top b2d_checker u_b2d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

// The bench pushes unsigned numbers through the input channel and checks every
// digit beat that comes back against a decimal conversion of its own. A short
// table of hand-picked numbers runs first. It covers zero, the single digits,
// the jumps in digit count around powers of ten and the all-ones word. Random
// numbers follow in three phases with different amounts of idling on each side.
// One long hold-off on the result side forces the pipeline to back up into the
// input channel.

module tb_top;

  import b2d_pkg::*;

  // One expected result beat: an ASCII digit and the flag for the final digit.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_beat_t;

  localparam int          DIR_ROWS    = 21;
  localparam int          PHASE_ITEMS = 130;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_SLACK = 30;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Only the low VALUE_BITS bits of a number take part in the conversion.
  localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  logic [IN_W-1:0] in_value  = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CHAR_W-1:0] out_digit_char;
  logic            out_last_digit;

  // Idle rates in percent; the main process changes them from phase to phase.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // A one-cycle pulse from the main process starts the long result hold-off.
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;

  digit_beat_t digits_due[$];
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  // Directed numbers. Where the text is filled in it is the expected decimal
  // string, typed by hand; an empty text means the predictor supplies it.
  logic [IN_W-1:0] dir_value [DIR_ROWS] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd255, 32'd256,
    32'd65535, 32'd65536, 32'd999999999, 32'd1000000000, 32'd2147483647,
    32'd2147483648, 32'd3999999999, 32'd4000000000, 32'd4294967294,
    32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890
  };
  string dir_text [DIR_ROWS] = '{
    "0", "1", "9", "10", "", "", "", "",
    "", "", "", "1000000000", "",
    "", "", "", "",
    "4294967295", "", "", ""
  };

  binary_to_decimal_ascii_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A correct run ends long before CYCLE_LIMIT, so hitting the
  // limit means the block has hung or lost beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Counts down the long hold-off in its own process, so the sender keeps
  // offering numbers while the result side is blocked.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side stall: random idling at the current rate, forced high
  // during the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 1) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Checker. The values read here are the ones the block saw at this edge,
  // since every signal involved is updated with nonblocking assignments.
  // The error count is only touched here, so it is bumped directly.
  always @(posedge clk) begin
    digit_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digits_due.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected digit beat, expected none, got char %0d last %0b",
                 $time, out_digit_char, out_last_digit);
      end else begin
        want = digits_due.pop_front();
        if (out_digit_char !== want.ch) begin
          errors = errors + 1;
          $display("%0t: digit_char mismatch, expected %0d, got %0d",
                   $time, want.ch, out_digit_char);
        end
        if (out_last_digit !== want.last) begin
          errors = errors + 1;
          $display("%0t: last_digit mismatch, expected %0b, got %0b",
                   $time, want.last, out_last_digit);
        end
      end
    end
  end

  // Predictor: queues the decimal digits of a number, most significant
  // first, with the final digit flagged. Zero gives the single digit '0'.
  function automatic void expect_decimal(input logic [IN_W-1:0] raw);
    logic [31:0] rest;
    logic [3:0]  rev[$];
    digit_beat_t beat;
    rest = 32'(raw & VALUE_MASK);
    do begin
      rev.push_back(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    for (int k = rev.size() - 1; k >= 0; k--) begin
      beat.ch   = ASCII_ZERO + CHAR_W'(rev[k]);
      beat.last = (k == 0);
      digits_due.push_back(beat);
    end
  endfunction

  // Random numbers with a spread of digit counts. A plain 32-bit draw mostly
  // has ten digits, so most draws aim at a chosen digit count, sit next to a
  // power of ten, or are a power of two or its bitwise complement.
  function automatic logic [IN_W-1:0] random_number();
    longint unsigned pow;
    longint unsigned hi;
    longint unsigned lo;
    int unsigned     ndig;
    pow = 1;
    case ($urandom_range(3))
      0: begin
        return IN_W'($urandom);
      end
      1: begin
        ndig = $urandom_range(1, 10);
        repeat (ndig - 1) pow = pow * 10;
        lo = (ndig == 1) ? 0 : pow;
        hi = pow * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return IN_W'($urandom_range(32'(hi), 32'(lo)));
      end
      2: begin
        // Just around a power of ten, where the digit count changes.
        repeat ($urandom_range(9)) pow = pow * 10;
        return IN_W'(pow + 2 - $urandom_range(4));
      end
      default: begin
        pow = 64'd1 << $urandom_range(IN_W - 1);
        return $urandom_range(1) ? IN_W'(pow) : ~IN_W'(pow);
      end
    endcase
  endfunction

  // Offers one number and waits until it is taken. Before the offer the
  // sender idles cycle by cycle at the current rate. Expectations are queued
  // at the accepting edge, well before the first digit can appear.
  task automatic offer_number(input logic [IN_W-1:0] v, input string text);
    digit_beat_t beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() == 0) begin
      expect_decimal(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        beat.ch   = CHAR_W'(text[i]);
        beat.last = (i == text.len() - 1);
        digits_due.push_back(beat);
      end
    end
  endtask

  // Stops offering and waits until every queued digit has come out.
  task automatic wait_digits_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (digits_due.size() != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: the sender idles now and then, the receiver about half the time.
    tx_idle_pct <= 30;
    rx_idle_pct <= 52;
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_number(dir_value[r], dir_text[r]);
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_number(random_number(), "");
    end
    wait_digits_drained();

    // Phase two: the roles swap, so gaps land on other points of the work.
    tx_idle_pct <= 52;
    rx_idle_pct <= 30;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_number(random_number(), "");
    end
    wait_digits_drained();

    // Phase three: no idling at all. It opens with the long hold-off, so the
    // pipeline fills and the block has to stall its input.
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      offer_number(random_number(), "");
    end
    wait_digits_drained();

    // A final idle wait catches any stray beat after the last expected digit.
    repeat (DRAIN_SLACK) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
